// ===== rtl/dcsr_pkg.sv =====
// Package for the dense-to-CSR compressor.
// Holds the fixed field widths, the result record and register index codes.
// Depends on nothing.
package dcsr_pkg;

	localparam int VALUE_W = 64;
	localparam int CFG_W   = 11;
	localparam int IDX_W   = 11;
	localparam int PTR_W   = 21;
	localparam int CFG_IDX_W = 1;
	localparam int SIZE_LIMIT = 2047;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_POINTER = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [VALUE_W-1:0] entry_value;
		logic [IDX_W-1:0]   column_index;
		logic [IDX_W-1:0]   row_slot;
		logic [PTR_W-1:0]   pointer;
		logic               last;
	} dcsr_result_t;

	typedef struct packed {
		logic [1:0]              count;
		dcsr_result_t [2:0]      res;
	} dcsr_bundle_t;

endpackage

// ===== rtl/dcsr_elem_if.sv =====
// Channel carrying one dense matrix element per beat.
// Depends on dcsr_pkg.
interface dcsr_elem_if;
	logic                        valid;
	logic                        ready;
	logic [dcsr_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/dcsr_entry_if.sv =====
// Channel carrying one CSR result (data entry or row pointer) per beat.
// Depends on dcsr_pkg.
interface dcsr_entry_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [dcsr_pkg::VALUE_W-1:0] entry_value;
	logic [dcsr_pkg::IDX_W-1:0]   column_index;
	logic [dcsr_pkg::IDX_W-1:0]   row_slot;
	logic [dcsr_pkg::PTR_W-1:0]   pointer;
	logic                         last;

	modport source (output valid, output kind, output entry_value, output column_index,
		output row_slot, output pointer, output last, input ready);
	modport sink (input valid, input kind, input entry_value, input column_index,
		input row_slot, input pointer, input last, output ready);
endinterface

// ===== rtl/dcsr_core.sv =====
// Input register, matrix position state and the per-element result logic.
// Produces a bundle of up to three results per element. Depends on dcsr_pkg.
module dcsr_core #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         elem_valid,
	output logic                         elem_ready,
	input  logic [dcsr_pkg::VALUE_W-1:0] elem_value,
	input  logic [dcsr_pkg::CFG_W-1:0]   num_rows,
	input  logic [dcsr_pkg::CFG_W-1:0]   num_cols,
	output logic                         bundle_valid,
	input  logic                         bundle_ready,
	output dcsr_pkg::dcsr_bundle_t       bundle
);
	import dcsr_pkg::*;

	localparam int ROW_LIM = (MAX_ROWS > SIZE_LIMIT) ? SIZE_LIMIT : MAX_ROWS;
	localparam int COL_LIM = (MAX_COLS > SIZE_LIMIT) ? SIZE_LIMIT : MAX_COLS;
	localparam int RPOS_W  = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;
	localparam int CPOS_W  = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;

	logic               valid_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [CPOS_W-1:0]  col_pos_q;
	logic [RPOS_W-1:0]  row_pos_q;
	logic [PTR_W-1:0]   count_q;
	logic               has_entry_q;

	logic [CFG_W-1:0]   rows_eff;
	logic [CFG_W-1:0]   cols_eff;
	logic               nonzero;
	logic [PTR_W-1:0]   count_inc;
	logic [CFG_W:0]     col_next;
	logic [CFG_W:0]     row_next;
	logic               row_end;
	logic               mat_end;
	logic               advance;
	dcsr_result_t [3:0] cand;
	logic [3:0]         cand_en;
	logic [1:0]         n;

	always_comb begin
		if (num_rows == '0) begin
			rows_eff = CFG_W'(1);
		end else if (num_rows > CFG_W'(ROW_LIM)) begin
			rows_eff = CFG_W'(ROW_LIM);
		end else begin
			rows_eff = num_rows;
		end
		if (num_cols == '0) begin
			cols_eff = CFG_W'(1);
		end else if (num_cols > CFG_W'(COL_LIM)) begin
			cols_eff = CFG_W'(COL_LIM);
		end else begin
			cols_eff = num_cols;
		end
	end

	assign nonzero   = |value_s1[VALUE_W-2:0];
	assign count_inc = nonzero ? count_q + PTR_W'(1) : count_q;
	assign col_next  = (CFG_W+1)'(col_pos_q) + (CFG_W+1)'(1);
	assign row_next  = (CFG_W+1)'(row_pos_q) + (CFG_W+1)'(1);
	assign row_end   = col_next >= {1'b0, cols_eff};
	assign mat_end   = row_end && (row_next >= {1'b0, rows_eff});

	always_comb begin
		cand = '0;
		cand[0].kind         = KIND_DATA;
		cand[0].entry_value  = value_s1;
		cand[0].column_index = col_next[IDX_W-1:0];
		cand[1].kind         = KIND_POINTER;
		cand[1].row_slot     = IDX_W'(row_pos_q);
		cand[1].pointer      = count_inc;
		cand[2].kind         = KIND_POINTER;
		cand[2].row_slot     = IDX_W'(row_pos_q);
		cand[2].pointer      = count_inc + PTR_W'(1);
		cand[3].kind         = KIND_POINTER;
		cand[3].row_slot     = rows_eff;
		cand[3].pointer      = count_inc + PTR_W'(1);
		cand[3].last         = 1'b1;
		cand_en[0] = nonzero;
		cand_en[1] = nonzero && !has_entry_q;
		cand_en[2] = row_end && !has_entry_q && !nonzero;
		cand_en[3] = mat_end;

		n = '0;
		bundle.res = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand_en[i]) begin
				if (n < 2'd3) begin
					bundle.res[n] = cand[i];
				end
				n = n + 2'd1;
			end
		end
		bundle.count = n;
	end

	assign bundle_valid = valid_s1;
	assign advance      = valid_s1 && bundle_ready;
	assign elem_ready   = !valid_s1 || bundle_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (elem_ready) begin
			valid_s1 <= elem_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (elem_ready && elem_valid) begin
			value_s1 <= elem_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q   <= '0;
			row_pos_q   <= '0;
			count_q     <= '0;
			has_entry_q <= 1'b0;
		end else if (advance) begin
			if (row_end) begin
				col_pos_q   <= '0;
				has_entry_q <= 1'b0;
				if (mat_end) begin
					row_pos_q <= '0;
					count_q   <= '0;
				end else begin
					row_pos_q <= row_next[RPOS_W-1:0];
					count_q   <= count_inc;
				end
			end else begin
				col_pos_q   <= col_next[CPOS_W-1:0];
				has_entry_q <= has_entry_q || nonzero;
				count_q     <= count_inc;
			end
		end
	end

endmodule

// ===== rtl/dcsr_serializer.sv =====
// Output register that holds one bundle and sends its results one beat each.
// Depends on dcsr_pkg.
module dcsr_serializer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   bundle_valid,
	output logic                   bundle_ready,
	input  dcsr_pkg::dcsr_bundle_t bundle,
	output logic                   out_valid,
	input  logic                   out_ready,
	output dcsr_pkg::dcsr_result_t out_result
);
	import dcsr_pkg::*;

	dcsr_result_t [2:0] res_q;
	logic [1:0]         cnt_q;
	logic               pop;

	assign out_valid    = cnt_q != '0;
	assign out_result   = res_q[0];
	assign pop          = out_valid && out_ready;
	assign bundle_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (bundle_valid && bundle_ready) begin
			cnt_q <= bundle.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bundle_valid && bundle_ready) begin
			res_q <= bundle.res;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

// ===== rtl/dense_to_csr_compressor.sv =====
// Top level of the dense-to-CSR compressor.
// Depends on dcsr_pkg, dcsr_elem_if, dcsr_entry_if, dcsr_core and dcsr_serializer.
//
// The elements channel takes one IEEE double bit pattern per beat, in row-major
// order. The entries channel returns the compressed matrix: a data entry for each
// nonzero element, one row pointer per row, and a final pointer flagged last after
// the last element. The matrix size comes from num_rows and num_cols, written over
// the cfg_we, cfg_index and cfg_data port; write them only while the block is idle,
// which the block itself does not enforce. An element is held in an input register
// and its results are then loaded into an output register, from which the first
// result of an element is presented. An element with at most one result lets the
// block sustain one element per cycle while the receiver takes every beat; an
// element with several results holds the output register until each is sent.
// When the receiver stalls, the output register holds its results and the input
// register fills, after which the elements channel is stalled. Reset clears the
// matrix position and entry count, empties both registers and sets both sizes to 1.
module dense_to_csr_compressor #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dcsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcsr_pkg::CFG_W-1:0]     cfg_data,
	dcsr_elem_if.sink                      elements,
	dcsr_entry_if.source                   entries
);
	import dcsr_pkg::*;

	logic [CFG_W-1:0] num_rows_q;
	logic [CFG_W-1:0] num_cols_q;
	logic             bundle_valid;
	logic             bundle_ready;
	dcsr_bundle_t     bundle;
	dcsr_result_t     out_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= CFG_W'(1);
			num_cols_q <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_ROWS: num_rows_q <= cfg_data;
				CFG_NUM_COLS: num_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dcsr_core #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.elem_valid   (elements.valid),
		.elem_ready   (elements.ready),
		.elem_value   (elements.value),
		.num_rows     (num_rows_q),
		.num_cols     (num_cols_q),
		.bundle_valid (bundle_valid),
		.bundle_ready (bundle_ready),
		.bundle       (bundle)
	);

	dcsr_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle_valid (bundle_valid),
		.bundle_ready (bundle_ready),
		.bundle       (bundle),
		.out_valid    (entries.valid),
		.out_ready    (entries.ready),
		.out_result   (out_result)
	);

	assign entries.kind         = out_result.kind;
	assign entries.entry_value  = out_result.entry_value;
	assign entries.column_index = out_result.column_index;
	assign entries.row_slot     = out_result.row_slot;
	assign entries.pointer      = out_result.pointer;
	assign entries.last         = out_result.last;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for dense_to_csr_compressor: streams dense matrices, predicts the CSR entries
// and row pointers beat by beat and checks every result in order.
// Depends on dcsr_pkg, dcsr_elem_if, dcsr_entry_if and the RTL of the block.
module tb;
	import dcsr_pkg::*;

	localparam int MAX_ROWS = 1024;
	localparam int MAX_COLS = 1024;
	localparam int IDLE_LIMIT = 2000;
	localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	dcsr_elem_if  elem ();
	dcsr_entry_if ent ();

	dense_to_csr_compressor #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.elements(elem),
		.entries(ent)
	);

	logic [CFG_W-1:0] rows_reg = 11'd1;
	logic [CFG_W-1:0] cols_reg = 11'd1;
	int               col_pos = 0;
	int               row_pos = 0;
	logic [PTR_W-1:0] entry_total = '0;
	bit               row_open = 1'b0;
	dcsr_result_t     entries_due[$];
	int               errors = 0;
	int               gap_pct = 0;
	int               stall_pct = 0;
	int               idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		ent.ready <= 1'b0;
		forever begin
			@(posedge clk);
			ent.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic int clamp_size(input logic [CFG_W-1:0] reg_value, input int max_size);
		if (reg_value == 0)
			return 1;
		if (reg_value > max_size)
			return max_size;
		return int'(reg_value);
	endfunction

	function automatic void push_pointer(input int slot, input logic [PTR_W-1:0] ptr,
		input logic is_last);
		dcsr_result_t r;
		r = '0;
		r.kind = KIND_POINTER;
		r.row_slot = IDX_W'(slot);
		r.pointer = ptr;
		r.last = is_last;
		entries_due.push_back(r);
	endfunction

	function automatic void compress_element(input logic [VALUE_W-1:0] v);
		int           rows_eff;
		int           cols_eff;
		dcsr_result_t r;
		rows_eff = clamp_size(rows_reg, MAX_ROWS);
		cols_eff = clamp_size(cols_reg, MAX_COLS);
		if (v[VALUE_W-2:0] != '0) begin
			entry_total = entry_total + 1'b1;
			r = '0;
			r.kind = KIND_DATA;
			r.entry_value = v;
			r.column_index = IDX_W'(col_pos + 1);
			entries_due.push_back(r);
			if (!row_open) begin
				push_pointer(row_pos, entry_total, 1'b0);
				row_open = 1'b1;
			end
		end
		if (col_pos + 1 >= cols_eff) begin
			if (!row_open)
				push_pointer(row_pos, entry_total + 1'b1, 1'b0);
			col_pos = 0;
			row_open = 1'b0;
			if (row_pos + 1 >= rows_eff) begin
				push_pointer(rows_eff, entry_total + 1'b1, 1'b1);
				row_pos = 0;
				entry_total = '0;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
	endfunction

	function automatic void report_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin
		dcsr_result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_NUM_ROWS)
					rows_reg = cfg_data;
				else
					cols_reg = cfg_data;
			end
			if (elem.valid && elem.ready)
				compress_element(elem.value);
			if (ent.valid && ent.ready) begin
				if (entries_due.size() == 0) begin
					errors++;
					$display("%0t unexpected beat: expected none, actual kind %b value %h ptr %h",
						$time, ent.kind, ent.entry_value, ent.pointer);
				end else begin
					want = entries_due.pop_front();
					report_field("kind", 64'(want.kind), 64'(ent.kind));
					report_field("entry_value", want.entry_value, ent.entry_value);
					report_field("column_index", 64'(want.column_index),
						64'(ent.column_index));
					report_field("row_slot", 64'(want.row_slot), 64'(ent.row_slot));
					report_field("pointer", 64'(want.pointer), 64'(ent.pointer));
					report_field("last", 64'(want.last), 64'(ent.last));
				end
			end
			if ((elem.valid && elem.ready) || (ent.valid && ent.ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	task automatic send_element(input logic [VALUE_W-1:0] v);
		if ($urandom_range(99) < gap_pct) begin
			elem.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		elem.valid <= 1'b1;
		elem.value <= v;
		do
			@(posedge clk);
		while (!elem.ready);
	endtask

	function automatic logic [VALUE_W-1:0] pick_element(input int zero_pct);
		if ($urandom_range(99) < zero_pct)
			return $urandom_range(1) ? NEG_ZERO : 64'h0;
		case ($urandom_range(11))
			0: return 64'h7FF8_0000_0000_0000;
			1: return 64'hFFF0_0000_0000_0000;
			2: return 64'hFFFF_FFFF_FFFF_FFFF;
			3: return 64'h0000_0000_0000_0001;
			4: return 64'h8000_0000_0000_0001;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_elements(input int count, input int zero_pct);
		repeat (count)
			send_element(pick_element(zero_pct));
	endtask

	task automatic wait_drained;
		elem.valid <= 1'b0;
		@(posedge clk);
		while (entries_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
		cfg_we <= 1'b1;
		cfg_index <= CFG_NUM_ROWS;
		cfg_data <= rows;
		@(posedge clk);
		cfg_index <= CFG_NUM_COLS;
		cfg_data <= cols;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_zero_detect;
		gap_pct = 0;
		stall_pct = 65;
		send_element(64'h0);
		send_element(NEG_ZERO);
		send_element(64'h3FF0_0000_0000_0000);
		send_element(64'hBFF0_0000_0000_0000);
		send_element(64'h7FF8_0000_0000_0000);
		send_element(64'h7FF0_0000_0000_0000);
		send_element(64'h0000_0000_0000_0001);
		send_element(64'h8000_0000_0000_0001);
		send_element(64'hFFFF_FFFF_FFFF_FFFF);
		wait_drained();
	endtask

	task automatic test_row_layout;
		gap_pct = 21;
		stall_pct = 21;
		set_size(11'd3, 11'd4);
		send_element(64'h0);
		send_element(64'h4014_0000_0000_0000);
		send_element(NEG_ZERO);
		send_element(64'h401C_0000_0000_0000);
		repeat (4) send_element(64'h0);
		send_element(64'hC000_0000_0000_0000);
		send_element(64'h0);
		send_element(NEG_ZERO);
		send_element(64'h7FEF_FFFF_FFFF_FFFF);
		wait_drained();
	endtask

	task automatic test_size_limits;
		gap_pct = 0;
		stall_pct = 21;
		set_size(11'd0, 11'd0);
		send_elements(3, 50);
		wait_drained();
		set_size(11'd2047, 11'd1);
		send_elements(20, 50);
		wait_drained();
		set_size(11'd0, 11'd0);
		send_elements(2, 50);
		wait_drained();
		set_size(11'd1, 11'd2047);
		send_elements(30, 90);
		wait_drained();
		set_size(11'd0, 11'd0);
		send_elements(2, 50);
		wait_drained();
	endtask

	task automatic test_resize_midway;
		gap_pct = 21;
		stall_pct = 65;
		set_size(11'd2, 11'd8);
		send_elements(5, 50);
		wait_drained();
		set_size(11'd2, 11'd3);
		send_elements(2, 50);
		wait_drained();
		set_size(11'd1, 11'd3);
		send_elements(2, 50);
		wait_drained();
	endtask

	task automatic test_random_matrices;
		int sent;
		int rows;
		int cols;
		int zero_pct;
		logic [CFG_W-1:0] rows_w;
		logic [CFG_W-1:0] cols_w;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 65;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 65;
				end
				default: begin
					gap_pct = 21;
					stall_pct = 21;
				end
			endcase
			sent = 0;
			while (sent < 20) begin
				rows = $urandom_range(1, 5);
				cols = $urandom_range(1, 8);
				rows_w = (rows == 1 && $urandom_range(1)) ? 11'd0 : CFG_W'(rows);
				cols_w = (cols == 1 && $urandom_range(1)) ? 11'd0 : CFG_W'(cols);
				zero_pct = $urandom_range(3) * 33;
				wait_drained();
				set_size(rows_w, cols_w);
				repeat ($urandom_range(1, 3)) begin
					send_elements(rows * cols, zero_pct);
					sent += rows * cols;
				end
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_NUM_ROWS;
		cfg_data <= '0;
		elem.valid <= 1'b0;
		elem.value <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_detect();
		test_row_layout();
		test_size_limits();
		test_resize_midway();
		test_random_matrices();
		repeat (10) @(posedge clk);
		errors += entries_due.size();
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
